// ===== design/imsd_pkg.sv =====
package imsd_pkg;

  // Fixed field widths of the block.
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned LEVEL_W    = 15;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // Averaging is new = (9 * old + motion) / 10, with the motion scaled up.
  localparam int unsigned AVG_MUL          = 9;
  localparam int unsigned AVG_DIV          = 10;
  // Extra numerator bits over the 16-bit motion: 9 * old + new stays below 10 * 2^16.
  localparam int unsigned AVG_NUM_EXTRA    = 4;
  localparam int unsigned DIV_BITS_PER_CYC = 4;

  // Register reset values.
  localparam logic [14:0] ONE_G_RST     = 15'd8192;
  localparam logic [15:0] STEP_HIGH_RST = 16'd10240;
  localparam logic [15:0] STEP_LOW_RST  = 16'd6963;
  localparam logic [15:0] DEBOUNCE_RST  = 16'd250;
  localparam logic [15:0] WRIST_THR_RST = 16'd9600;

  typedef enum logic [2:0] {
    REG_ONE_G      = 3'd0,
    REG_STEP_HIGH  = 3'd1,
    REG_STEP_LOW   = 3'd2,
    REG_DEBOUNCE   = 3'd3,
    REG_WRIST_RATE = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_sel_e;

  typedef struct packed {
    logic [14:0] one_g;
    logic [15:0] step_high_threshold;
    logic [15:0] step_low_threshold;
    logic [15:0] debounce_ms;
    logic [15:0] wrist_rate_threshold;
  } cfg_t;

  typedef struct packed {
    logic      load;
    logic      square;
    axis_sel_e sq_sel;
    logic      root_step;
    logic      post;
    logic      div_step;
    logic      commit;
  } dp_cmd_t;

  // Number of divide-by-ten steps, four quotient bits per cycle.
  function automatic int unsigned div_digits(int unsigned frac_bits);
    return (MAG_W + AVG_NUM_EXTRA + frac_bits + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC;
  endfunction

endpackage

// ===== design/imsd_regs.sv =====
module imsd_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [imsd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [imsd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [imsd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output imsd_pkg::cfg_t                    cfg_o
);
  import imsd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ONE_G:      cfg_d.one_g                = pwdata[14:0];
        REG_STEP_HIGH:  cfg_d.step_high_threshold  = pwdata[15:0];
        REG_STEP_LOW:   cfg_d.step_low_threshold   = pwdata[15:0];
        REG_DEBOUNCE:   cfg_d.debounce_ms          = pwdata[15:0];
        REG_WRIST_RATE: cfg_d.wrist_rate_threshold = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ONE_G:      prdata = APB_DATA_W'(cfg_q.one_g);
      REG_STEP_HIGH:  prdata = APB_DATA_W'(cfg_q.step_high_threshold);
      REG_STEP_LOW:   prdata = APB_DATA_W'(cfg_q.step_low_threshold);
      REG_DEBOUNCE:   prdata = APB_DATA_W'(cfg_q.debounce_ms);
      REG_WRIST_RATE: prdata = APB_DATA_W'(cfg_q.wrist_rate_threshold);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_g                <= ONE_G_RST;
      cfg_q.step_high_threshold  <= STEP_HIGH_RST;
      cfg_q.step_low_threshold   <= STEP_LOW_RST;
      cfg_q.debounce_ms          <= DEBOUNCE_RST;
      cfg_q.wrist_rate_threshold <= WRIST_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/imsd_ctrl.sv =====
module imsd_ctrl #(
  parameter int unsigned SAMPLE_BITS           = 16,
  parameter int unsigned AVERAGE_FRACTION_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output imsd_pkg::dp_cmd_t cmd_o
);
  import imsd_pkg::*;

  localparam int unsigned DIGITS  = div_digits(AVERAGE_FRACTION_BITS);
  localparam int unsigned CNT_MAX = (SAMPLE_BITS > DIGITS) ? SAMPLE_BITS : DIGITS;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_POST,
    ST_DIV,
    ST_COMMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  dp_cmd_t          cmd;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd        = '0;
    cmd.sq_sel = AXIS_X;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          cnt_d    = '0;
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        cmd.sq_sel = axis_sel_e'(cnt_q[1:0]);
        if (cnt_q == CNT_W'(AXIS_Z)) begin
          cnt_d   = '0;
          state_d = ST_ROOT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_q == CNT_W'(SAMPLE_BITS - 1)) begin
          cnt_d   = '0;
          state_d = ST_POST;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_POST: begin
        cmd.post = 1'b1;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIGITS - 1)) begin
          state_d = ST_COMMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.commit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // A new result must never overwrite one that is still waiting.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over a pending result");

  // An accepted item always starts the squaring phase.
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SQUARE))
    else $error("accepted item did not start processing");

endmodule

// ===== design/imsd_dpath.sv =====
module imsd_dpath #(
  parameter int unsigned SAMPLE_BITS           = 16,
  parameter int unsigned AVERAGE_FRACTION_BITS = 8,
  parameter int unsigned STEP_COUNT_BITS       = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  imsd_pkg::dp_cmd_t                   cmd_i,
  input  imsd_pkg::cfg_t                      cfg_i,
  input  logic signed [SAMPLE_BITS-1:0]       accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0]       accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0]       accel_z_i,
  input  logic signed [SAMPLE_BITS-1:0]       gyro_y_i,
  input  logic                                gyro_valid_i,
  input  logic [imsd_pkg::TIME_W-1:0]         time_ms_i,
  input  logic                                consume_wrist_i,
  output logic [imsd_pkg::MAG_W-1:0]          magnitude_o,
  output logic [imsd_pkg::MAG_W-1:0]          motion_raw_o,
  output logic [imsd_pkg::LEVEL_W-1:0]        motion_level_o,
  output logic [STEP_COUNT_BITS-1:0]          step_count_o,
  output logic                                step_taken_o,
  output logic                                wrist_raised_o
);
  import imsd_pkg::*;

  localparam int unsigned S      = SAMPLE_BITS;
  localparam int unsigned F      = AVERAGE_FRACTION_BITS;
  localparam int unsigned SUM_W  = 2 * S;
  localparam int unsigned REM_W  = S + 1;
  localparam int unsigned AVG_W  = MAG_W + F;
  localparam int unsigned NUM_W  = AVG_W + AVG_NUM_EXTRA;
  localparam int unsigned NUM_PW = DIV_BITS_PER_CYC * div_digits(F);
  localparam int unsigned CMP_W  = S + THR_W;

  // Captured item.
  logic [S-1:0]      ax_q, ay_q, az_q, gy_q;
  logic              gvalid_q, consume_q;
  logic [TIME_W-1:0] time_q;

  // Square, root and divide working registers.
  logic [SUM_W-1:0]  sum_q;
  logic [REM_W-1:0]  rem_q;
  logic [S-1:0]      root_q;
  logic [MAG_W-1:0]  mag_q, motion_q;
  logic [NUM_PW-1:0] num_q;
  logic [3:0]        div_rem_q;

  // Running state.
  logic [AVG_W-1:0]           avg_q;
  logic                       peak_q;
  logic [TIME_W-1:0]          last_q;
  logic [STEP_COUNT_BITS-1:0] steps_q;
  logic                       wrist_q;

  logic [S-1:0]      ax_abs, ay_abs, az_abs, gy_abs, sq_op;
  logic [SUM_W-1:0]  sq_prod;
  logic [REM_W+1:0]  rem_sh, trial;
  logic              root_bit;
  logic [S+MAG_W-1:0] root_ext;
  logic [MAG_W-1:0]  mag_c, motion_c, one_g_ext;
  logic [NUM_W-1:0]  num_init;
  logic [NUM_PW-1:0] num_nxt;
  logic [4:0]        div_r;
  logic [MAG_W-1:0]  level_raw;
  logic [LEVEL_W-1:0] level_c;
  logic [TIME_W-1:0] elapsed;
  logic              peak_start, step_c, gyro_over, wrist_now;

  always_comb begin
    ax_abs = accel_x_i[S-1] ? S'(-accel_x_i) : S'(accel_x_i);
    ay_abs = accel_y_i[S-1] ? S'(-accel_y_i) : S'(accel_y_i);
    az_abs = accel_z_i[S-1] ? S'(-accel_z_i) : S'(accel_z_i);
    gy_abs = gyro_y_i[S-1]  ? S'(-gyro_y_i)  : S'(gyro_y_i);
  end

  // One shared multiplier squares the three axes on successive cycles.
  always_comb begin
    case (cmd_i.sq_sel)
      AXIS_X:  sq_op = ax_q;
      AXIS_Y:  sq_op = ay_q;
      AXIS_Z:  sq_op = az_q;
      default: sq_op = '0;
    endcase
    sq_prod = SUM_W'(sq_op) * SUM_W'(sq_op);
  end

  // Restoring square root, one result bit per cycle.
  always_comb begin
    rem_sh   = {rem_q, sum_q[SUM_W-1 -: 2]};
    trial    = {1'b0, root_q, 2'b01};
    root_bit = (rem_sh >= trial);
  end

  // Magnitude saturation and distance from one g.
  always_comb begin
    root_ext  = (S + MAG_W)'(root_q);
    mag_c     = (|root_ext[S+MAG_W-1:MAG_W]) ? '1 : root_ext[MAG_W-1:0];
    one_g_ext = MAG_W'(cfg_i.one_g);
    motion_c  = (mag_c >= one_g_ext) ? (mag_c - one_g_ext) : (one_g_ext - mag_c);
    num_init  = NUM_W'({avg_q, 3'b000}) + NUM_W'(avg_q) + (NUM_W'(motion_c) << F);
  end

  // Divide by ten, four quotient bits a cycle; quotient bits shift in at the bottom.
  always_comb begin
    div_r   = {1'b0, div_rem_q};
    num_nxt = num_q;
    for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
      div_r   = {div_r[3:0], num_nxt[NUM_PW-1]};
      num_nxt = {num_nxt[NUM_PW-2:0], 1'b0};
      if (div_r >= 5'(AVG_DIV)) begin
        div_r      = div_r - 5'(AVG_DIV);
        num_nxt[0] = 1'b1;
      end
    end
  end

  // Result and state update once the new average is known.
  always_comb begin
    level_raw  = num_q[AVG_W-1:F];
    level_c    = (level_raw > MAG_W'(cfg_i.one_g)) ? cfg_i.one_g : level_raw[LEVEL_W-1:0];
    elapsed    = time_q - last_q;
    peak_start = (mag_q > cfg_i.step_high_threshold) && !peak_q;
    step_c     = peak_start && (elapsed > TIME_W'(cfg_i.debounce_ms));
    gyro_over  = CMP_W'(gy_q) > CMP_W'(cfg_i.wrist_rate_threshold);
    wrist_now  = wrist_q || (gvalid_q && gyro_over);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q      <= ax_abs;
      ay_q      <= ay_abs;
      az_q      <= az_abs;
      gy_q      <= gy_abs;
      gvalid_q  <= gyro_valid_i;
      consume_q <= consume_wrist_i;
      time_q    <= time_ms_i;
      sum_q     <= '0;
      rem_q     <= '0;
      root_q    <= '0;
    end else if (cmd_i.square) begin
      sum_q <= sum_q + sq_prod;
    end else if (cmd_i.root_step) begin
      sum_q <= sum_q << 2;
      if (root_bit) begin
        rem_q <= REM_W'(rem_sh - trial);
      end else begin
        rem_q <= REM_W'(rem_sh);
      end
      root_q <= {root_q[S-2:0], root_bit};
    end
    if (cmd_i.post) begin
      mag_q    <= mag_c;
      motion_q <= motion_c;
      num_q    <= NUM_PW'(num_init);
    end else if (cmd_i.div_step) begin
      num_q <= num_nxt;
    end
    if (cmd_i.commit) begin
      magnitude_o    <= mag_q;
      motion_raw_o   <= motion_q;
      motion_level_o <= level_c;
      step_count_o   <= step_c ? (steps_q + STEP_COUNT_BITS'(1)) : steps_q;
      step_taken_o   <= step_c;
      wrist_raised_o <= wrist_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_rem_q <= '0;
      avg_q     <= '0;
      peak_q    <= 1'b0;
      last_q    <= '0;
      steps_q   <= '0;
      wrist_q   <= 1'b0;
    end else begin
      if (cmd_i.post) begin
        div_rem_q <= '0;
      end else if (cmd_i.div_step) begin
        div_rem_q <= div_r[3:0];
      end
      if (cmd_i.commit) begin
        avg_q   <= num_q[AVG_W-1:0];
        wrist_q <= consume_q ? 1'b0 : wrist_now;
        if (peak_start) begin
          peak_q <= 1'b1;
        end else if (mag_q < cfg_i.step_low_threshold) begin
          peak_q <= 1'b0;
        end
        if (step_c) begin
          steps_q <= steps_q + STEP_COUNT_BITS'(1);
          last_q  <= time_q;
        end
      end
    end
  end

  // The divider remainder always stays a decimal digit.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rem_q < 4'(AVG_DIV))
    else $error("divide-by-ten remainder out of range");

  // A counted step advances the counter by exactly one.
  a_step_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && step_c) |=> (steps_q == $past(steps_q) + STEP_COUNT_BITS'(1)))
    else $error("step counter did not advance");

  // The counter moves only when a result is committed.
  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(steps_q))
    else $error("step counter changed outside a commit");

endmodule

// ===== design/imu_motion_step_detector.sv =====
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid_i/tready_o       one IMU sample item
// m_axis    out        m_axis_tvalid_o/tready_i       one result item per sample
// apb       in/out     psel, penable, pwrite, pready  five configuration registers
//
// After an item is accepted, the shared multiplier squares the three axes, the restoring
// square root forms the magnitude (one bit per cycle), the average numerator is formed,
// the divide by ten of the average runs (four bits per cycle) and a commit step loads
// the output register; the block then returns to idle and can accept the next item.
// One item is in work at a time.
// The output register holds a finished result while the next item is accepted and worked
// on; a stall on the output side only stops the block when the next result is ready.
// Reset is asynchronous and active low; it clears the averaging, step and wrist state
// and loads the register defaults.
module imu_motion_step_detector #(
  parameter int unsigned SAMPLE_BITS           = 16,
  parameter int unsigned AVERAGE_FRACTION_BITS = 8,
  parameter int unsigned STEP_COUNT_BITS       = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Bits from the lowest: accel_x, accel_y, accel_z, gyro_y (SAMPLE_BITS each),
  // gyro_valid, time_ms (32), consume_wrist, zero fill to whole bytes.
  input  logic [((4*SAMPLE_BITS+34+7)/8)*8-1:0]  s_axis_tdata_i,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // Bits from the lowest: magnitude (16), motion_raw (16), motion_level (15),
  // step_count (STEP_COUNT_BITS), step_taken, wrist_raised, zero fill to whole bytes.
  output logic [((STEP_COUNT_BITS+49+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [imsd_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [imsd_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [imsd_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                    pready
);
  import imsd_pkg::*;

  localparam int unsigned S         = SAMPLE_BITS;
  localparam int unsigned TIME_LSB  = 4 * S + 1;
  localparam int unsigned CONS_BIT  = 4 * S + TIME_W + 1;
  localparam int unsigned LVL_LSB   = 2 * MAG_W;
  localparam int unsigned CNT_LSB   = LVL_LSB + LEVEL_W;
  localparam int unsigned TAKEN_BIT = CNT_LSB + STEP_COUNT_BITS;
  localparam int unsigned OUT_RAW   = TAKEN_BIT + 2;

  cfg_t    cfg;
  dp_cmd_t cmd;

  logic [MAG_W-1:0]           magnitude, motion_raw;
  logic [LEVEL_W-1:0]         motion_level;
  logic [STEP_COUNT_BITS-1:0] step_count;
  logic                       step_taken, wrist_raised;

  imsd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  imsd_ctrl #(
    .SAMPLE_BITS           (SAMPLE_BITS),
    .AVERAGE_FRACTION_BITS (AVERAGE_FRACTION_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  imsd_dpath #(
    .SAMPLE_BITS           (SAMPLE_BITS),
    .AVERAGE_FRACTION_BITS (AVERAGE_FRACTION_BITS),
    .STEP_COUNT_BITS       (STEP_COUNT_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .accel_x_i       (s_axis_tdata_i[0 +: S]),
    .accel_y_i       (s_axis_tdata_i[S +: S]),
    .accel_z_i       (s_axis_tdata_i[2*S +: S]),
    .gyro_y_i        (s_axis_tdata_i[3*S +: S]),
    .gyro_valid_i    (s_axis_tdata_i[4*S]),
    .time_ms_i       (s_axis_tdata_i[TIME_LSB +: TIME_W]),
    .consume_wrist_i (s_axis_tdata_i[CONS_BIT]),
    .magnitude_o     (magnitude),
    .motion_raw_o    (motion_raw),
    .motion_level_o  (motion_level),
    .step_count_o    (step_count),
    .step_taken_o    (step_taken),
    .wrist_raised_o  (wrist_raised)
  );

  always_comb begin
    m_axis_tdata_o              = '0;
    m_axis_tdata_o[OUT_RAW-1:0] = {wrist_raised, step_taken, step_count, motion_level,
                                   motion_raw, magnitude};
  end

endmodule

// ===== tb/imsd_motion_checker.sv =====
`timescale 1ns / 100ps

// Watches the sample and result channels and the register port of the step detector,
// keeps its own copy of the detector state and predicts every result item.
module imsd_motion_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Bits from the lowest: accel_x, accel_y, accel_z, gyro_y, gyro_valid, time_ms,
  // consume_wrist, zero fill.
  input  logic [103:0]                    s_tdata_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  // Bits from the lowest: magnitude, motion_raw, motion_level, step_count, step_taken,
  // wrist_raised, zero fill.
  input  logic [87:0]                     m_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [imsd_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [imsd_pkg::APB_DATA_W-1:0] pwdata_i,
  input  logic                            pready_i,
  output int unsigned                     mismatch_count,
  output int unsigned                     expected_depth,
  output int unsigned                     results_checked,
  output int unsigned                     steps_seen,
  output int unsigned                     wrist_seen
);
  import imsd_pkg::*;

  typedef struct packed {
    logic [15:0] magnitude;
    logic [15:0] motion_raw;
    logic [14:0] motion_level;
    logic [31:0] step_count;
    logic        step_taken;
    logic        wrist_raised;
  } motion_result_t;

  cfg_t           cfg;
  logic [63:0]    motion_avg;
  bit             peak_active;
  logic [31:0]    last_step_time;
  logic [31:0]    steps_total;
  bit             wrist_latch;
  motion_result_t pending_results[$];
  motion_result_t oldest;
  logic [31:0]    want[6];
  logic [31:0]    got[6];
  bit             result_bad;
  string          field_name[6] = '{"magnitude", "motion_raw", "motion_level",
                                    "step_count", "step_taken", "wrist_raised"};

  // Floor square root, two bits of the radicand per pass.
  function automatic logic [15:0] floor_root(logic [63:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = radicand;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (root > 64'hFFFF) return 16'hFFFF;
    return root[15:0];
  endfunction

  task automatic apply_reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
    case (reg_idx_e'(addr[APB_ADDR_W-1:2]))
      REG_ONE_G:      cfg.one_g                = value[14:0];
      REG_STEP_HIGH:  cfg.step_high_threshold  = value[15:0];
      REG_STEP_LOW:   cfg.step_low_threshold   = value[15:0];
      REG_DEBOUNCE:   cfg.debounce_ms          = value[15:0];
      REG_WRIST_RATE: cfg.wrist_rate_threshold = value[15:0];
      default: ;
    endcase
  endtask

  task automatic predict_motion_result(logic [103:0] word);
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gy;
    logic               gvalid;
    logic               consume;
    logic [31:0]        now;
    logic [31:0]        since;
    longint             sum_sq;
    logic [15:0]        mag;
    int unsigned        motion;
    int unsigned        gy_abs;
    logic [63:0]        level;
    motion_result_t     res;
    ax      = word[15:0];
    ay      = word[31:16];
    az      = word[47:32];
    gy      = word[63:48];
    gvalid  = word[64];
    now     = word[96:65];
    consume = word[97];

    sum_sq = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    mag    = floor_root(sum_sq);
    motion = (mag >= cfg.one_g) ? mag - cfg.one_g : cfg.one_g - mag;

    motion_avg = (9 * motion_avg + (64'(motion) << 8)) / 10;
    level      = motion_avg >> 8;
    if (level > cfg.one_g) level = cfg.one_g;

    res.step_taken = 1'b0;
    if (mag > cfg.step_high_threshold && !peak_active) begin
      peak_active = 1'b1;
      since       = now - last_step_time;
      if (since > cfg.debounce_ms) begin
        steps_total    = steps_total + 1;
        last_step_time = now;
        res.step_taken = 1'b1;
      end
    end else if (mag < cfg.step_low_threshold) begin
      peak_active = 1'b0;
    end

    if (gvalid) begin
      gy_abs = (gy < 0) ? -int'(gy) : int'(gy);
      if (gy_abs > cfg.wrist_rate_threshold) wrist_latch = 1'b1;
    end
    res.wrist_raised = wrist_latch;
    if (consume) wrist_latch = 1'b0;

    res.magnitude    = mag;
    res.motion_raw   = motion[15:0];
    res.motion_level = level[14:0];
    res.step_count   = steps_total;
    pending_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.one_g                = ONE_G_RST;
      cfg.step_high_threshold  = STEP_HIGH_RST;
      cfg.step_low_threshold   = STEP_LOW_RST;
      cfg.debounce_ms          = DEBOUNCE_RST;
      cfg.wrist_rate_threshold = WRIST_THR_RST;
      motion_avg      = '0;
      peak_active     = 1'b0;
      last_step_time  = '0;
      steps_total     = '0;
      wrist_latch     = 1'b0;
      pending_results.delete();
      mismatch_count  = 0;
      results_checked = 0;
      steps_seen      = 0;
      wrist_seen      = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) apply_reg_write(paddr_i, pwdata_i);
      if (s_tvalid_i && s_tready_i) predict_motion_result(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (pending_results.size() == 0) begin
          if (mismatch_count < 40)
            $display("%0t: result item with no sample waiting: expected none, got %h",
                     $time, m_tdata_i);
          mismatch_count++;
        end else begin
          oldest  = pending_results.pop_front();
          want[0] = oldest.magnitude;
          want[1] = oldest.motion_raw;
          want[2] = oldest.motion_level;
          want[3] = oldest.step_count;
          want[4] = oldest.step_taken;
          want[5] = oldest.wrist_raised;
          got[0]  = m_tdata_i[15:0];
          got[1]  = m_tdata_i[31:16];
          got[2]  = m_tdata_i[46:32];
          got[3]  = m_tdata_i[78:47];
          got[4]  = m_tdata_i[79];
          got[5]  = m_tdata_i[80];
          result_bad = 1'b0;
          for (int f = 0; f < 6; f++) begin
            if (want[f] != got[f]) begin
              if (mismatch_count < 40)
                $display("%0t: %s expected %0d, got %0d", $time, field_name[f], want[f],
                         got[f]);
              result_bad = 1'b1;
            end
          end
          if (result_bad) mismatch_count++;
          results_checked++;
          if (got[4]) steps_seen++;
          if (got[5]) wrist_seen++;
        end
      end
    end
    expected_depth = pending_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Top of the step detector testbench. It makes the clock and the single reset, feeds
// sample items and drains result items with random idle cycles on both sides, writes
// the configuration registers between phases, and gives the verdict. All prediction
// and comparison lives in the checker instance.
module testbench;
  import imsd_pkg::*;

  // Cycle limit for the whole run; it leaves a wide margin over the slowest correct run.
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 225;

  // One IMU sample as the stimulus side sees it.
  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gy;
    logic               gvalid;
    logic [31:0]        tms;
    logic               consume;
  } imu_sample_t;

  logic                  clk_i;
  logic                  rst_ni;
  // Bits from the lowest: accel_x, accel_y, accel_z, gyro_y (16 each), gyro_valid,
  // time_ms (32), consume_wrist, zero fill to 104 bits.
  logic [103:0]          s_axis_tdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  // Bits from the lowest: magnitude (16), motion_raw (16), motion_level (15),
  // step_count (32), step_taken, wrist_raised, zero fill to 88 bits.
  logic [87:0]           m_axis_tdata_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatch_count;
  int unsigned expected_depth;
  int unsigned results_checked;
  int unsigned steps_seen;
  int unsigned wrist_seen;

  // Idle switches for the two sides, changed in stretches by the stimulus.
  bit          sender_idle;
  bit          sink_idle;
  int unsigned cycle_count;
  int unsigned samples_sent;
  int unsigned settings_used;

  // Register values last written, used to aim the walking samples at the thresholds.
  int unsigned cfg_one_g;
  int unsigned cfg_high;
  int unsigned cfg_low;
  int unsigned cfg_debounce;
  int unsigned cfg_wrist;
  logic [31:0] now_ms;
  bit          walk_high;

  imu_motion_step_detector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  imsd_motion_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tdata_i       (s_axis_tdata_i),
    .s_tvalid_i      (s_axis_tvalid_i),
    .s_tready_i      (s_axis_tready_o),
    .m_tdata_i       (m_axis_tdata_o),
    .m_tvalid_i      (m_axis_tvalid_o),
    .m_tready_i      (m_axis_tready_i),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .mismatch_count  (mismatch_count),
    .expected_depth  (expected_depth),
    .results_checked (results_checked),
    .steps_seen      (steps_seen),
    .wrist_seen      (wrist_seen)
  );

  // 2 ns clock period.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Present one sample item, after a random gap while sender_idle is set, and hold it
  // until the block takes it. The task returns at the edge of acceptance with tvalid
  // still high, so a following item with no gap keeps tvalid high without a drop.
  task automatic send_sample(imu_sample_t smp);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, smp.consume, smp.tms, smp.gvalid, smp.gy, smp.az, smp.ay,
                        smp.ax};
    do @(posedge clk_i); while (!s_axis_tready_o);
    samples_sent++;
  endtask

  task automatic send_fields(int ax, int ay, int az, int gy, bit gv, logic [31:0] tms,
                             bit consume);
    imu_sample_t smp;
    smp.ax      = 16'(ax);
    smp.ay      = 16'(ay);
    smp.az      = 16'(az);
    smp.gy      = 16'(gy);
    smp.gvalid  = gv;
    smp.tms     = tms;
    smp.consume = consume;
    send_sample(smp);
  endtask

  // Drop the sample valid and wait until every predicted result has been drained.
  // The first edge lets the checker record the item accepted at the current edge.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_depth != 0);
  endtask

  // One APB write: a setup cycle, then an access cycle held until pready, then the
  // bus returns to idle so that the next write starts on a fresh edge.
  task automatic write_reg(reg_idx_e idx, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(int unsigned one_g, int unsigned high, int unsigned low,
                                int unsigned debounce, int unsigned wrist);
    write_reg(REG_ONE_G, one_g);
    write_reg(REG_STEP_HIGH, high);
    write_reg(REG_STEP_LOW, low);
    write_reg(REG_DEBOUNCE, debounce);
    write_reg(REG_WRIST_RATE, wrist);
    // The one_g register keeps 15 bits, so a written 32768 reads as zero.
    cfg_one_g    = one_g & 32'h7FFF;
    cfg_high     = high;
    cfg_low      = low;
    cfg_debounce = debounce;
    cfg_wrist    = wrist;
    settings_used++;
  endtask

  // Build one random sample. Most are a walk: the magnitude swings between above the
  // high threshold and below the low one, sometimes sits exactly on a threshold or in
  // the hysteresis band, and the timestamp creeps forward on the scale of the debounce
  // time. The rest is noise over the full field ranges.
  task automatic make_sample(output imu_sample_t smp);
    int unsigned kind;
    int unsigned target;
    int unsigned axis;
    int          comp;
    int          side1;
    int          side2;
    int          gy_val;
    kind        = $urandom_range(0, 99);
    smp.gvalid  = 1'($urandom_range(0, 1));
    smp.consume = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) == 0) begin
      // Rate right around the wrist threshold, either sign.
      gy_val = int'(cfg_wrist) + int'($urandom_range(0, 2)) - 1;
      if (gy_val > 32767) gy_val = 32767;
      smp.gy = 16'($urandom_range(0, 1) ? -gy_val : gy_val);
    end else begin
      smp.gy = 16'($urandom);
    end

    if (kind < 25) begin
      smp.ax  = 16'($urandom);
      smp.ay  = 16'($urandom);
      smp.az  = 16'($urandom);
      smp.tms = (kind < 5) ? $urandom : now_ms;
    end else begin
      if (kind < 35) begin
        case ($urandom_range(0, 3))
          0:       target = cfg_high;
          1:       target = cfg_high + 1;
          2:       target = cfg_low;
          default: target = (cfg_low > 0) ? cfg_low - 1 : 0;
        endcase
      end else if (kind < 50 && cfg_high > cfg_low) begin
        target = $urandom_range(cfg_low, cfg_high);
      end else if (walk_high) begin
        target = cfg_high + 1 + $urandom_range(0, 4000);
      end else begin
        target = (cfg_low > 0) ? $urandom_range(0, cfg_low - 1) : 0;
      end
      if (target > 46000) target = 46000;
      if ($urandom_range(0, 2) == 0) walk_high = !walk_high;

      // Exact-threshold samples up to 32767 use a single clean axis so the magnitude is exact.
      side2 = (kind < 35) ? 0 : int'($urandom_range(0, 200)) - 100;
      if (target > 32767) begin
        comp  = target * 181 / 256;
        side1 = comp;
      end else begin
        comp  = target;
        side1 = (kind < 35) ? 0 : int'($urandom_range(0, 200)) - 100;
        if (comp > 32767) comp = 32767;
      end
      if ($urandom_range(0, 1)) comp = -comp;
      axis = $urandom_range(0, 2);
      case (axis)
        0: begin
          smp.ax = 16'(comp);
          smp.ay = 16'(side1);
          smp.az = 16'(side2);
        end
        1: begin
          smp.ay = 16'(comp);
          smp.az = 16'(side1);
          smp.ax = 16'(side2);
        end
        default: begin
          smp.az = 16'(comp);
          smp.ax = 16'(side1);
          smp.ay = 16'(side2);
        end
      endcase
      now_ms  = now_ms + $urandom_range(0, cfg_debounce / 3 + 20);
      smp.tms = now_ms;
    end
  endtask

  // While sink_idle is set, the result side stalls a random number of cycles before each item.
  initial begin
    int unsigned hold;
    m_axis_tready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = sink_idle ? $urandom_range(0, 7) : 0;
      if (hold != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Guard against a hung block.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit with %0d results still expected",
             expected_depth);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    imu_sample_t smp;
    int unsigned one_g;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    rst_ni          <= 1'b0;
    sender_idle   = 1'b1;
    sink_idle     = 1'b1;
    samples_sent  = 0;
    settings_used = 1;
    walk_high     = 1'b1;
    now_ms        = 32'h100;
    cfg_one_g     = ONE_G_RST;
    cfg_high      = STEP_HIGH_RST;
    cfg_low       = STEP_LOW_RST;
    cfg_debounce  = DEBOUNCE_RST;
    cfg_wrist     = WRIST_THR_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples under the reset register values (one g 8192, high 10240,
    // low 6963, debounce 250, wrist 9600).
    send_fields(0, 0, 0, 0, 0, 0, 0);
    // Most negative axes, largest sum of squares. The early time lies inside the
    // debounce window after reset, so the peak latches without a step. The most
    // negative gyro rate counts as 32768 and sets the wrist latch.
    send_fields(-32768, -32768, -32768, -32768, 1, 100, 0);
    // Peak still active: no step. An invalid gyro reading leaves the latch alone.
    send_fields(32767, 32767, 32767, 32767, 0, 300, 0);
    // Below the low threshold rearms; consume reports the latch and then clears it.
    send_fields(0, 0, 1000, 0, 0, 304, 1);
    // Exactly on the high threshold does not start a peak, one above does.
    send_fields(0, 0, 10240, 0, 0, 400, 0);
    send_fields(0, 0, 10241, 0, 0, 404, 0);
    // Exactly on the low threshold does not rearm.
    send_fields(0, 0, 6963, 0, 0, 408, 0);
    send_fields(0, 0, 12000, 0, 0, 900, 0);
    send_fields(0, 0, 6962, 0, 0, 904, 0);
    // A time difference equal to the debounce time is blocked, one more counts.
    send_fields(0, 0, 12000, 0, 0, 654, 0);
    send_fields(3000, 4000, 0, 0, 0, 658, 0);
    send_fields(12000, 0, 0, 0, 0, 655, 0);
    // Timestamps across the 32-bit wrap.
    send_fields(0, 0, 0, 9601, 1, 32'hFFFF_FF00, 0);
    send_fields(0, -20000, 0, -9600, 1, 32'hFFFF_FF10, 1);
    send_fields(0, 0, 0, -9601, 0, 32'hFFFF_FFF8, 0);
    send_fields(0, 0, -30000, 0, 0, 32'h0000_0020, 0);
    send_fields(100, -100, 50, 32767, 1, 32'h0000_0024, 0);
    send_fields(-32768, 0, 0, 0, 0, 32'h0000_0030, 0);
    send_fields(32767, -1, 1, 0, 0, 32'h0000_0040, 1);
    send_fields(-1, -1, -1, 0, 0, 32'h0000_0044, 0);

    // Random phases, each under its own register setting: the reset values written
    // back, a stiff one g, the smallest one g with thresholds at the far ends, one g
    // of zero with the high threshold below the low one, then random settings.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: apply_settings(ONE_G_RST, STEP_HIGH_RST, STEP_LOW_RST, DEBOUNCE_RST,
                          WRIST_THR_RST);
        1: apply_settings(16384, 20480, 13926, 250, 9600);
        2: apply_settings(1, 65535, 0, 0, 0);
        3: apply_settings(32768, 0, 65535, 65535, 32768);
        default: begin
          one_g = $urandom_range(1, 16384);
          apply_settings(one_g, one_g + $urandom_range(0, one_g / 2),
                         one_g - $urandom_range(0, one_g / 4), $urandom_range(0, 500),
                         $urandom_range(0, 32768));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Change the idle pattern in stretches, including stretches with none.
        if (n % 50 == 0) begin
          sender_idle = $urandom_range(0, 1);
          sink_idle   = $urandom_range(0, 1);
        end
        make_sample(smp);
        send_sample(smp);
      end
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("Covered %0d samples under %0d register settings, walking and noise mixed.",
             samples_sent, settings_used);
    $display("Checked %0d results: %0d counted steps, %0d with the wrist flag set.",
             results_checked, steps_seen, wrist_seen);
    if (mismatch_count == 0 && expected_depth == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
